// ----- hdl/spm_pkg.sv -----
package spm_pkg;

    // Pattern window size and text index width
    localparam int PATTERN_MAX = 32;
    localparam int INDEX_WIDTH = 32;

    // Index counter saturates at min(2^INDEX_WIDTH - 1, 2^32 - 1)
    localparam int CNT_W = (INDEX_WIDTH > 32) ? 32 : INDEX_WIDTH;

    // Length fits up to PATTERN_MAX (32 here)
    localparam int LEN_W = 7;

    // Pattern storage: four 64-bit words of eight bytes
    localparam int PAT_WORDS = 4;
    localparam int PAT_BYTES = 32;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_LEN_BITS = 6;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_3 = 3'd4;

    // Text byte handed from one cell to the next
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } spm_link_t;

endpackage

// ----- hdl/spm_cell.sv -----
module spm_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  logic              clear,
    input  spm_pkg::spm_link_t link_in,
    input  logic [7:0]        pat_byte,
    input  logic              active,
    output spm_pkg::spm_link_t link_out,
    output logic              hit
);
    import spm_pkg::*;

    spm_link_t link_reg;
    spm_link_t link_next;

    // Restart empties the window behind the newest byte
    always_comb begin
        link_next = clear ? '0 : link_in;
    end

    // Hold one text byte, pass it on at each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg.valid <= 1'b0;
        end else if (shift_en) begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

    // Cells beyond the pattern length always agree
    assign hit = !active || (link_next.valid && (link_next.data == pat_byte));

endmodule

// ----- hdl/streaming_pattern_matcher.sv -----
// Streaming byte pattern matcher (Knuth-Morris-Pratt semantics, window form).
// Input stream: s_tdata carries one text byte, s_tuser marks the first byte
// of a new text. Output stream: one result per byte; m_tuser says a pattern
// occurrence ends at this byte, m_tdata gives its start index and the running
// occurrence count of the current text (the count saturates at all ones).
// Config channel: cfg_index selects length (0) or pattern word 0..3 (1..4);
// other indexes are ignored. Write only while the stream is idle.
// Timing: a result is registered in the cycle after its byte is accepted, and
// one byte is accepted every cycle unless the output stalls. The rate is set by
// the compare across the row of PATTERN_MAX cells, each holding one window byte.
// Reset: pattern length 1, pattern all zero, window empty, counters zero.
// Stall: the result sits in the output register; while it is not taken,
// s_tready is low and no byte enters. Ready returns in the cycle it is taken.
module streaming_pattern_matcher (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: [7:0] text_char
    input  logic [7:0]                       s_tdata,
    // s_tuser: [0] restart
    input  logic                             s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // m_tdata: [31:0] match_start, [63:32] match_tally
    output logic [63:0]                      m_tdata,
    // m_tuser: [0] match_found
    output logic                             m_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [spm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import spm_pkg::*;

    localparam int PB = PATTERN_MAX;

    // Configuration state
    logic [LEN_W-1:0]      eff_len_reg, eff_len_next;
    logic [63:0]           pat_word_reg  [PAT_WORDS];
    logic [63:0]           pat_word_next [PAT_WORDS];
    logic [8*PB-1:0]       align_reg, align_next;
    logic [8*PB-1:0]       pat_vec, pat_rev;
    logic [LEN_W-1:0]      len_field, shift_bytes;
    logic                  cfg_fire;

    // Stream state
    logic [CNT_W-1:0]      seen_reg, seen_next, cur_index;
    logic [31:0]           occ_reg, occ_next, occ_cur;
    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [31:0]           out_start_reg, out_start_next;
    logic [31:0]           out_tally_reg;
    logic                  s_fire;
    logic                  found;
    logic [CNT_W:0]        start_full;

    spm_link_t             link [PB+1];
    logic [PB-1:0]         hit_vec;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Register file next values
    always_comb begin
        len_field = {1'b0, cfg_data[CFG_LEN_BITS-1:0]};
        eff_len_next = eff_len_reg;
        for (int w = 0; w < PAT_WORDS; w++) begin
            pat_word_next[w] = pat_word_reg[w];
        end
        if (cfg_fire) begin
            case (cfg_index)
                REG_LENGTH: eff_len_next = (len_field > LEN_W'(PB)) ? LEN_W'(PB) : len_field;
                REG_WORD_0: pat_word_next[0] = cfg_data;
                REG_WORD_1: pat_word_next[1] = cfg_data;
                REG_WORD_2: pat_word_next[2] = cfg_data;
                REG_WORD_3: pat_word_next[3] = cfg_data;
                default: ;
            endcase
        end
    end

    // Pattern bytes in window order: aligned byte j = pattern[len-1-j]
    for (genvar k = 0; k < PB; k++) begin : g_pat
        if (k < PAT_BYTES) begin : g_real
            assign pat_vec[k*8 +: 8] = pat_word_next[k/8][(k%8)*8 +: 8];
        end else begin : g_zero
            assign pat_vec[k*8 +: 8] = 8'h00;
        end
        assign pat_rev[k*8 +: 8] = pat_vec[(PB-1-k)*8 +: 8];
    end

    assign shift_bytes = LEN_W'(PB) - eff_len_next;
    assign align_next  = pat_rev >> {shift_bytes, 3'b000};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_len_reg <= LEN_W'(1);
            align_reg   <= '0;
            for (int w = 0; w < PAT_WORDS; w++) begin
                pat_word_reg[w] <= '0;
            end
        end else if (cfg_fire) begin
            eff_len_reg <= eff_len_next;
            align_reg   <= align_next;
            for (int w = 0; w < PAT_WORDS; w++) begin
                pat_word_reg[w] <= pat_word_next[w];
            end
        end
    end

    // Request handshake: the output register frees in the cycle it is taken
    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // Row of window cells, newest byte in cell 0
    assign link[0] = '{valid: 1'b1, data: s_tdata};

    for (genvar j = 0; j < PB; j++) begin : g_cell
        spm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (s_fire),
            .clear    ((j != 0) && s_tuser),
            .link_in  (link[j]),
            .pat_byte (align_reg[j*8 +: 8]),
            .active   (LEN_W'(j) < eff_len_reg),
            .link_out (link[j+1]),
            .hit      (hit_vec[j])
        );
    end

    assign found = (eff_len_reg != '0) && (&hit_vec);

    // Index and occurrence counters
    always_comb begin
        cur_index  = s_tuser ? '0 : seen_reg;
        seen_next  = (&cur_index) ? cur_index : cur_index + CNT_W'(1);
        occ_cur    = s_tuser ? '0 : occ_reg;
        occ_next   = (found && !(&occ_cur)) ? occ_cur + 32'd1 : occ_cur;
        start_full = {1'b0, cur_index} + (CNT_W+1)'(1) - (CNT_W+1)'(eff_len_reg);
        out_start_next = found ? 32'(start_full) : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            occ_reg  <= '0;
        end else if (s_fire) begin
            seen_reg <= seen_next;
            occ_reg  <= occ_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_found_reg <= found;
            out_start_reg <= out_start_next;
            out_tally_reg <= occ_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {out_tally_reg, out_start_reg};

    // A reported occurrence is always counted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[63:32] != 32'd0))
        else $error("match reported with zero tally");

    // No occurrence means a zero start index
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[31:0] == 32'd0))
        else $error("start index set without a match");

    // A restart byte is text index zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser) |=> (seen_reg == CNT_W'(1)))
        else $error("index not restarted");

    // An empty output register never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output");

endmodule
